### design/lppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_pkg
// Types and constants shared by the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam logic [15:0] HDR_LEN    = 16'd3;  // length bytes plus type byte
  localparam logic [15:0] LIST_START = 16'd7;  // first entry byte of a list frame
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_COUNT  = 2'd2,
    PH_ENTRY  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] position;
    logic [7:0]  frame_type;
    logic        is_list_frame;
    logic        frame_end;
    logic        closed;
    logic        malformed;
  } out_item_t;

endpackage
`default_nettype wire

### design/length_prefixed_packet_deframer.sv
`default_nettype none
// Each result is registered before it is presented. One byte per cycle while
// in_stall is low; the per-byte counter update is one short compare and
// increment path between the input and the result register.
// A skid stage holds one extra result while the output side stalls.
// Reset (rst_n low, synchronous) returns to header hunt with counters cleared.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Byte-stream deframer for length-prefixed and counted-entry list frames.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lppd_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lppd_pkg::out_item_t      out_item
);

  logic                take;
  lppd_pkg::out_item_t result;

  assign take = in_valid && !in_stall;

  lppd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (in_item),
    .result (result)
  );

  lppd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### design/lppd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_core
// Frame tracking state and the per-byte result logic.
// ----------------------------------------------------------------------------
module lppd_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire lppd_pkg::in_item_t item,
  output lppd_pkg::out_item_t    result
);

  logic [15:0]      byte_count_r, byte_count_nxt;
  logic [15:0]      frame_length_r, frame_length_nxt;
  logic [7:0]       type_byte_r, type_byte_nxt;
  logic [31:0]      exp_entries_r, exp_entries_nxt;
  logic [31:0]      entries_done_r, entries_done_nxt;
  logic [7:0]       entry_left_r, entry_left_nxt;
  lppd_pkg::phase_t phase_r, phase_nxt;

  always_comb begin
    logic        fin;
    logic        bad;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [31:0] done_inc;
    logic [7:0]  left_dec;

    b        = item.rx_byte;
    pos      = byte_count_r;
    fin      = 1'b0;
    bad      = 1'b0;
    done_inc = entries_done_r + 32'd1;
    left_dec = entry_left_r - 8'd1;

    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    type_byte_nxt    = type_byte_r;
    exp_entries_nxt  = exp_entries_r;
    entries_done_nxt = entries_done_r;
    entry_left_nxt   = entry_left_r;
    phase_nxt        = phase_r;

    case (phase_r)
      lppd_pkg::PH_HEADER: begin
        if (pos == 16'd0) begin
          frame_length_nxt = {b, 8'd0};
        end else if (pos == 16'd1) begin
          frame_length_nxt = {frame_length_r[15:8], b};
        end else begin
          type_byte_nxt = b;
          if (frame_length_r == 16'd0) begin
            phase_nxt = lppd_pkg::PH_COUNT;
          end else if (frame_length_r < lppd_pkg::HDR_LEN) begin
            bad = 1'b1;
          end else if (frame_length_r == lppd_pkg::HDR_LEN) begin
            fin = 1'b1;
          end else begin
            phase_nxt = lppd_pkg::PH_BODY;
          end
        end
      end
      lppd_pkg::PH_BODY: begin
        if (({1'b0, pos} + 17'd1) == {1'b0, frame_length_r}) begin
          fin = 1'b1;
        end
      end
      lppd_pkg::PH_COUNT: begin
        exp_entries_nxt = {exp_entries_r[23:0], b};
        if (pos == (lppd_pkg::LIST_START - 16'd1)) begin
          if ({exp_entries_r[23:0], b} == 32'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt        = lppd_pkg::PH_ENTRY;
            entry_left_nxt   = 8'd0;
            entries_done_nxt = 32'd0;
          end
        end
      end
      lppd_pkg::PH_ENTRY: begin
        // entry_left of zero means the next byte is an entry length
        if (entry_left_r == 8'd0) begin
          if (b == 8'd0) begin
            bad = 1'b1;
          end else begin
            entry_left_nxt = b;
          end
        end else begin
          entry_left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            entries_done_nxt = done_inc;
            if (done_inc == exp_entries_r) begin
              fin = 1'b1;
            end
          end
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    result.out_byte      = b;
    result.position      = pos;
    result.frame_type    = (pos >= 16'd2) ? type_byte_nxt : 8'd0;
    result.is_list_frame = (phase_nxt == lppd_pkg::PH_COUNT) ||
                           (phase_nxt == lppd_pkg::PH_ENTRY);
    result.frame_end     = fin;
    result.closed        = 1'b0;
    result.malformed     = bad;

    if (byte_count_r != lppd_pkg::POS_MAX) begin
      byte_count_nxt = byte_count_r + 16'd1;
    end

    // end of frame, bad length or peer close: back to header hunt
    if (fin || bad || item.mode) begin
      byte_count_nxt   = 16'd0;
      frame_length_nxt = 16'd0;
      type_byte_nxt    = 8'd0;
      exp_entries_nxt  = 32'd0;
      entries_done_nxt = 32'd0;
      entry_left_nxt   = 8'd0;
      phase_nxt        = lppd_pkg::PH_HEADER;
    end

    if (item.mode) begin
      result = '0;
      result.closed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= 16'd0;
      frame_length_r <= 16'd0;
      type_byte_r    <= 8'd0;
      exp_entries_r  <= 32'd0;
      entries_done_r <= 32'd0;
      entry_left_r   <= 8'd0;
      phase_r        <= lppd_pkg::PH_HEADER;
    end else if (take) begin
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      type_byte_r    <= type_byte_nxt;
      exp_entries_r  <= exp_entries_nxt;
      entries_done_r <= entries_done_nxt;
      entry_left_r   <= entry_left_nxt;
      phase_r        <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

### design/lppd_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_outbuf
// Result register with a skid stage; the input side is stalled (full) only
// while the skid stage holds a result.
// ----------------------------------------------------------------------------
module lppd_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lppd_pkg::out_item_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lppd_pkg::out_item_t      out_item
);

  logic                main_v_r, main_v_nxt;
  logic                skid_v_r, skid_v_nxt;
  lppd_pkg::out_item_t main_r, main_nxt;
  lppd_pkg::out_item_t skid_r, skid_nxt;
  logic                pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      // input is stalled while the skid stage holds a transfer
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire
